// File: sv/dfr_pkg.sv
// dfr_pkg: shared types, codes and reset constants of the delimited frame receiver
// no dependencies; compile first
`default_nettype none

package dfr_pkg;

    // default frame store depth, in bytes
    localparam int FRAME_BYTES_DEF = 6;

    // delivered frame width
    localparam int DATA_W = 48;
    localparam int DATA_BYTES = DATA_W / 8;

    // register reset values and the gap counter limit
    localparam logic [7:0] START_BYTE_RST = 8'hFD;
    localparam logic [7:0] END_BYTE_RST = 8'hFE;
    localparam logic [7:0] TIMEOUT_RST = 8'd5;
    localparam logic [7:0] GAP_MAX = 8'hFF;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_END_BYTE   = 2'd1,
        CFG_TIMEOUT    = 2'd2
    } t_cfg_idx;

    // input word opcodes
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    // result event codes
    typedef enum logic [1:0] {
        EV_DELIVER  = 2'd0,
        EV_OVERFLOW = 2'd1,
        EV_TIMEOUT  = 2'd2
    } t_event;

    // receiver phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RECV  = 2'd1,
        PH_ENDED = 2'd2,
        PH_ERROR = 2'd3
    } t_phase;

    // configuration register set
    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] timeout_ticks;
    } t_cfg;

    // one registered input word
    typedef struct packed {
        logic       valid;
        t_opcode    opcode;
        logic [7:0] rx_byte;
    } t_item;

    // result of one input word
    typedef struct packed {
        logic              valid;
        t_event            event_res;
        logic [DATA_W-1:0] frame_data;
    } t_result;

endpackage

`default_nettype wire

// File: sv/dfr_if.sv
// dfr_if: valid/ready channel interfaces for input words, results and configuration
// depends on dfr_pkg
`default_nettype none

// input channel: opcode and received byte
interface dfr_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

// result channel: event code and packed frame
interface dfr_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                event_res;
    logic [dfr_pkg::DATA_W-1:0] frame_data;

    modport source (output valid, output event_res, output frame_data, input ready);
    modport sink (input valid, input event_res, input frame_data, output ready);
endinterface

// configuration write channel
interface dfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/dfr_cfg_regs.sv
// dfr_cfg_regs: start byte, end byte and timeout registers
// depends on dfr_pkg and dfr_cfg_if
`default_nettype none

module dfr_cfg_regs (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dfr_cfg_if.sink      i_cfg_ch,
    output dfr_pkg::t_cfg o_cfg
);

    dfr_pkg::t_cfg r_cfg;
    dfr_pkg::t_cfg n_cfg;

    // writes are always taken
    assign i_cfg_ch.ready = 1'b1;

    // register decode, unknown indexes dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                dfr_pkg::CFG_START_BYTE: n_cfg.start_byte = i_cfg_ch.data;
                dfr_pkg::CFG_END_BYTE:   n_cfg.end_byte = i_cfg_ch.data;
                dfr_pkg::CFG_TIMEOUT:    n_cfg.timeout_ticks = i_cfg_ch.data;
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte <= dfr_pkg::START_BYTE_RST;
            r_cfg.end_byte <= dfr_pkg::END_BYTE_RST;
            r_cfg.timeout_ticks <= dfr_pkg::TIMEOUT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: sv/dfr_frame_core.sv
// dfr_frame_core: phase machine, gap timer, byte count and frame store
// depends on dfr_pkg
`default_nettype none

module dfr_frame_core #(
    parameter int FRAME_BYTES = dfr_pkg::FRAME_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  dfr_pkg::t_cfg    i_cfg,
    input  dfr_pkg::t_item   i_item,
    output dfr_pkg::t_result o_res
);

    localparam int CNT_W = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    dfr_pkg::t_phase r_phase;
    dfr_pkg::t_phase n_phase;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       r_gap;
    logic [7:0]       n_gap;
    logic [7:0]       r_store [FRAME_BYTES];

    logic             is_byte;
    logic             is_tick;
    logic             store_full;
    logic [7:0]       gap_inc;
    logic             timed_out;
    logic             store_wr;
    logic             store_clr;
    logic [dfr_pkg::DATA_W-1:0] packed_store;

    assign is_byte = i_item.valid && (i_item.opcode == dfr_pkg::OP_BYTE);
    assign is_tick = i_item.valid && (i_item.opcode == dfr_pkg::OP_TICK);
    assign store_full = (r_count >= CNT_W'(FRAME_BYTES));
    assign gap_inc = (r_gap == dfr_pkg::GAP_MAX) ? r_gap : r_gap + 8'd1;
    assign timed_out = (gap_inc > i_cfg.timeout_ticks);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (is_byte) begin
            case (r_phase)
                dfr_pkg::PH_IDLE: begin
                    if (i_item.rx_byte == i_cfg.start_byte) n_phase = dfr_pkg::PH_RECV;
                end
                dfr_pkg::PH_RECV: begin
                    if (i_item.rx_byte == i_cfg.end_byte) n_phase = dfr_pkg::PH_ENDED;
                    else if (store_full) n_phase = dfr_pkg::PH_ERROR;
                end
                default: n_phase = r_phase;
            endcase
        end else if (is_tick) begin
            case (r_phase)
                dfr_pkg::PH_RECV: begin
                    if (timed_out) n_phase = dfr_pkg::PH_IDLE;
                end
                default: n_phase = dfr_pkg::PH_IDLE;
            endcase
        end
    end

    // datapath controls and result
    always_comb begin
        n_count = r_count;
        n_gap = r_gap;
        store_wr = 1'b0;
        store_clr = 1'b0;
        o_res.valid = 1'b0;
        o_res.event_res = dfr_pkg::EV_DELIVER;
        o_res.frame_data = '0;
        if (is_byte) begin
            n_gap = '0;
            case (r_phase)
                dfr_pkg::PH_IDLE: begin
                    if (i_item.rx_byte == i_cfg.start_byte) n_count = '0;
                end
                dfr_pkg::PH_RECV: begin
                    if (i_item.rx_byte != i_cfg.end_byte && !store_full) begin
                        store_wr = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                default: n_count = r_count;
            endcase
        end else if (is_tick) begin
            case (r_phase)
                dfr_pkg::PH_IDLE: n_gap = '0;
                dfr_pkg::PH_RECV: begin
                    n_gap = timed_out ? 8'd0 : gap_inc;
                    if (timed_out) begin
                        o_res.valid = 1'b1;
                        o_res.event_res = dfr_pkg::EV_TIMEOUT;
                    end
                end
                dfr_pkg::PH_ERROR: begin
                    store_clr = 1'b1;
                    o_res.valid = 1'b1;
                    o_res.event_res = dfr_pkg::EV_OVERFLOW;
                end
                default: begin
                    store_clr = 1'b1;
                    o_res.valid = 1'b1;
                    o_res.event_res = dfr_pkg::EV_DELIVER;
                    o_res.frame_data = packed_store;
                end
            endcase
        end
    end

    // pack the store, first byte in the low bits
    for (genvar gi = 0; gi < dfr_pkg::DATA_BYTES; gi++) begin : g_pack
        if (gi < FRAME_BYTES) begin : g_used
            assign packed_store[8*gi +: 8] = r_store[gi];
        end else begin : g_zero
            assign packed_store[8*gi +: 8] = 8'd0;
        end
    end

    // frame store entries
    for (genvar gi = 0; gi < FRAME_BYTES; gi++) begin : g_store
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_store[gi] <= '0;
            end else if (store_clr) begin
                r_store[gi] <= '0;
            end else if (store_wr && (r_count[IDX_W-1:0] == IDX_W'(gi))) begin
                r_store[gi] <= i_item.rx_byte;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dfr_pkg::PH_IDLE;
            r_count <= '0;
            r_gap <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_gap <= n_gap;
        end
    end

    // byte count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FRAME_BYTES))
        else $error("byte count beyond store depth");

    // a result only comes from a tick
    a_res_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> is_tick)
        else $error("result without a tick");

    // a delivered or discarded frame leaves an empty store and idle phase
    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.event_res != dfr_pkg::EV_TIMEOUT)
        |=> (r_phase == dfr_pkg::PH_IDLE && packed_store == '0))
        else $error("store not cleared after frame end");

    // only a delivery carries data
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.event_res != dfr_pkg::EV_DELIVER) |-> o_res.frame_data == '0)
        else $error("data on a non-delivery event");

endmodule

`default_nettype wire

// File: sv/delimited_frame_receiver_top.sv
// delimited_frame_receiver_top: input register, frame core, result register
// depends on dfr_pkg, dfr_if, dfr_cfg_regs and dfr_frame_core
`default_nettype none

// Start/end-byte frame receiver with a gap timeout. Input words are received
// bytes (opcode 0) and poll ticks (opcode 1). A start byte opens a frame, an
// end byte closes it, data bytes in between fill a store of FRAME_BYTES bytes.
// On a tick an ended frame is delivered (event 0, first byte in the low bits
// of frame_data), an overflowed frame is discarded (event 1), and a frame with
// more than timeout_ticks ticks since its last byte is aborted (event 2, the
// store is kept). Each tick gives at most one result; bytes give none.
// One word is accepted per clock while the result register is free or taken: a
// word is captured in the input register and then processed into the result
// register, where its result is held until it is taken.
// The only stall is a held result: the input stage waits while the result
// register is full and not taken.
// Configuration writes are always ready and must be made while the block is
// idle.
module delimited_frame_receiver_top #(
    parameter int FRAME_BYTES = dfr_pkg::FRAME_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dfr_in_if.sink     i_in_ch,
    dfr_out_if.source  o_out_ch,
    dfr_cfg_if.sink    i_cfg_ch
);

    dfr_pkg::t_cfg    cfg;
    dfr_pkg::t_item   core_item;
    dfr_pkg::t_result core_res;

    logic                       r_in_valid;
    dfr_pkg::t_opcode           r_in_op;
    logic [7:0]                 r_in_byte;
    logic                       r_out_valid;
    dfr_pkg::t_event            r_out_event;
    logic [dfr_pkg::DATA_W-1:0] r_out_data;
    logic                       advance;

    dfr_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_ch (i_cfg_ch),
        .o_cfg    (cfg)
    );

    // the held word moves on when the result register can take its result
    assign advance = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_in_op <= dfr_pkg::t_opcode'(i_in_ch.opcode);
            r_in_byte <= i_in_ch.rx_byte;
        end
    end

    assign core_item.valid = advance;
    assign core_item.opcode = r_in_op;
    assign core_item.rx_byte = r_in_byte;

    dfr_frame_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_item  (core_item),
        .o_res   (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res.valid) begin
            r_out_event <= core_res.event_res;
            r_out_data <= core_res.frame_data;
        end
    end

    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.event_res = r_out_event;
    assign o_out_ch.frame_data = r_out_data;

    // a result is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out_ch.ready) |-> !core_res.valid)
        else $error("pending result overwritten");

    // a stalled word stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_op) && $stable(r_in_byte)))
        else $error("stalled word lost");

    // a result in the output register came from a processed word
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance))
        else $error("result without a processed word");

endmodule

`default_nettype wire

// File: test/testbench.sv
// testbench: self-checking bench for delimited_frame_receiver_top, directed words then random bursts
// depends on dfr_pkg, dfr_if and the receiver rtl; predicts every event and checks each result word
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dfr_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 12;
    localparam int FRAME_BYTES = FRAME_BYTES_DEF;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASE_WORDS = 60;
    localparam int DIRECTED_ROWS = 29;
    // index with no register behind it, writes must be dropped
    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

    // how a word's outcome is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_RESULT
    } t_check;

    typedef struct packed {
        t_opcode           op;
        logic [7:0]        rx_byte;
        t_check            chk;
        t_event            ev;
        logic [DATA_W-1:0] data;
    } t_word_plan;

    typedef struct packed {
        t_event            ev;
        logic [DATA_W-1:0] data;
    } t_frame_event;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dfr_in_if  word_ch ();
    dfr_out_if event_ch ();
    dfr_cfg_if cfg_ch ();

    delimited_frame_receiver_top #(
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (word_ch),
        .o_out_ch (event_ch),
        .i_cfg_ch (cfg_ch)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predicted receiver state and registers
    logic [7:0] cfg_start = START_BYTE_RST;
    logic [7:0] cfg_end = END_BYTE_RST;
    logic [7:0] cfg_timeout = TIMEOUT_RST;
    t_phase     rx_phase = PH_IDLE;
    logic [3:0] rx_count = '0;
    logic [7:0] rx_gap = '0;
    logic [7:0] rx_store [FRAME_BYTES] = '{default: 8'h00};

    // register values the stimulus is built around
    logic [7:0] gen_start = START_BYTE_RST;
    logic [7:0] gen_end = END_BYTE_RST;
    logic [7:0] gen_timeout = TIMEOUT_RST;

    t_word_plan   word_plans [$];
    t_frame_event expected_events [$];
    int           error_count = 0;
    int           words_sent = 0;
    bit           word_gaps_on = 1'b1;

    // result side back-pressure
    logic        sink_ready = 1'b0;
    int unsigned stall_left = 0;
    bit          stalls_on = 1'b1;
    int unsigned idle_cycles = 0;

    assign event_ch.ready = sink_ready;

    // directed words: extremes, ignored bytes, delivery, overflow, timeout, stale store
    t_word_plan directed_rows [DIRECTED_ROWS] = '{
        '{OP_TICK, 8'hFF, CHK_NONE,   EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'h00, CHK_NONE,   EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'hFD, CHK_NONE,   EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'hFF, CHK_NONE,   EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'hFD, CHK_NONE,   EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'hFE, CHK_NONE,   EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'h55, CHK_NONE,   EV_DELIVER,  48'h0},
        '{OP_TICK, 8'h00, CHK_RESULT, EV_DELIVER,  48'h0000_0000_FDFF},
        '{OP_BYTE, 8'hFD, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'h80, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'h7F, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'h00, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'hAA, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'h01, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'h55, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'h33, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'hFE, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_TICK, 8'hFF, CHK_RESULT, EV_OVERFLOW, 48'h0},
        '{OP_BYTE, 8'hFD, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'h11, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_TICK, 8'h00, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_TICK, 8'hFF, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_TICK, 8'h00, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_TICK, 8'hFF, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_TICK, 8'h00, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_TICK, 8'hFF, CHK_RESULT, EV_TIMEOUT,  48'h0},
        '{OP_BYTE, 8'hFD, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_BYTE, 8'hFE, CHK_MODEL,  EV_DELIVER,  48'h0},
        '{OP_TICK, 8'h00, CHK_RESULT, EV_DELIVER,  48'h0000_0000_0011}
    };

    // advance the predicted receiver by one word, returns 1 when an event is due
    function automatic bit framer_step(input t_opcode op, input logic [7:0] rx_byte,
                                       output t_event ev, output logic [DATA_W-1:0] data);
        bit hit;
        hit = 1'b0;
        ev = EV_DELIVER;
        data = '0;
        if (op == OP_BYTE) begin
            rx_gap = '0;
            case (rx_phase)
                PH_IDLE: begin
                    if (rx_byte == cfg_start) begin
                        rx_phase = PH_RECV;
                        rx_count = '0;
                    end
                end
                PH_RECV: begin
                    if (rx_byte == cfg_end) begin
                        rx_phase = PH_ENDED;
                    end else if (rx_count >= FRAME_BYTES) begin
                        rx_phase = PH_ERROR;
                    end else begin
                        rx_store[rx_count] = rx_byte;
                        rx_count = rx_count + 4'd1;
                    end
                end
                default: ;
            endcase
        end else begin
            case (rx_phase)
                PH_IDLE: rx_gap = '0;
                PH_RECV: begin
                    if (rx_gap != GAP_MAX) rx_gap = rx_gap + 8'd1;
                    if (rx_gap > cfg_timeout) begin
                        rx_gap = '0;
                        rx_phase = PH_IDLE;
                        ev = EV_TIMEOUT;
                        hit = 1'b1;
                    end
                end
                PH_ERROR: begin
                    foreach (rx_store[i]) rx_store[i] = '0;
                    rx_phase = PH_IDLE;
                    ev = EV_OVERFLOW;
                    hit = 1'b1;
                end
                default: begin
                    for (int i = 0; i < FRAME_BYTES; i++) begin
                        if (i < DATA_BYTES) data[8*i +: 8] = rx_store[i];
                    end
                    foreach (rx_store[i]) rx_store[i] = '0;
                    rx_phase = PH_IDLE;
                    ev = EV_DELIVER;
                    hit = 1'b1;
                end
            endcase
        end
        return hit;
    endfunction

    // predict on every accepted input word
    always @(posedge i_clk) begin : word_monitor
        t_word_plan        plan;
        t_event            ev;
        logic [DATA_W-1:0] data;
        bit                hit;
        if (i_rst_n && word_ch.valid && word_ch.ready) begin
            plan = word_plans.pop_front();
            hit = framer_step(t_opcode'(word_ch.opcode), word_ch.rx_byte, ev, data);
            case (plan.chk)
                CHK_MODEL: if (hit) expected_events.push_back('{ev, data});
                CHK_RESULT: expected_events.push_back('{plan.ev, plan.data});
                default: ;
            endcase
        end
    end

    // track register writes
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            case (t_cfg_idx'(cfg_ch.index))
                CFG_START_BYTE: cfg_start = cfg_ch.data;
                CFG_END_BYTE:   cfg_end = cfg_ch.data;
                CFG_TIMEOUT:    cfg_timeout = cfg_ch.data;
                default: ;
            endcase
        end
    end

    // compare each result word with the oldest expected event
    always @(posedge i_clk) begin : event_checker
        t_frame_event want;
        if (i_rst_n && event_ch.valid && event_ch.ready) begin
            if (expected_events.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, got event %0d data %h",
                         $time, event_ch.event_res, event_ch.frame_data);
            end else begin
                want = expected_events.pop_front();
                if (event_ch.event_res !== want.ev) begin
                    error_count++;
                    $display("%0t: event_res mismatch, expected %0d, got %0d",
                             $time, want.ev, event_ch.event_res);
                end
                if (event_ch.frame_data !== want.data) begin
                    error_count++;
                    $display("%0t: frame_data mismatch, expected %h, got %h",
                             $time, want.data, event_ch.frame_data);
                end
            end
        end
    end

    // random stalls on the result side, mostly short, some long, with stall-free stretches
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            sink_ready <= 1'b1;
            if (stalls_on && $urandom_range(0, 99) < 20) begin
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
            end
        end
        if ($urandom_range(0, 255) == 0) stalls_on <= !stalls_on;
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((word_ch.valid && word_ch.ready) || (event_ch.valid && event_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // drive one word and hold it until accepted, then maybe leave a gap
    task automatic send_word(input t_word_plan w);
        int unsigned gap;
        word_plans.push_back(w);
        word_ch.valid <= 1'b1;
        word_ch.opcode <= w.op;
        word_ch.rx_byte <= w.rx_byte;
        do @(posedge i_clk); while (!word_ch.ready);
        words_sent++;
        if (word_gaps_on && $urandom_range(0, 99) < 30) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            word_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] rx_byte);
        send_word('{OP_BYTE, rx_byte, CHK_MODEL, EV_DELIVER, '0});
    endtask

    task automatic send_tick();
        send_word('{OP_TICK, 8'($urandom_range(0, 255)), CHK_MODEL, EV_DELIVER, '0});
    endtask

    // wait until every expected event is out and the pipeline is quiet
    task automatic drain();
        word_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // program all three registers, optionally poking the unused index first
    task automatic write_cfg(input logic [7:0] start_val, input logic [7:0] end_val,
                             input logic [7:0] timeout_val, input bit poke_spare);
        if (poke_spare) put_reg(CFG_SPARE_IDX, ~timeout_val);
        put_reg(CFG_START_BYTE, start_val);
        put_reg(CFG_END_BYTE, end_val);
        put_reg(CFG_TIMEOUT, timeout_val);
        cfg_ch.valid <= 1'b0;
        gen_start = start_val;
        gen_end = end_val;
        gen_timeout = timeout_val;
    endtask

    // one random burst: mostly proper frames, some left to time out, some noise
    task automatic random_burst();
        int unsigned pick;
        int unsigned nbytes;
        int unsigned nticks;
        word_gaps_on = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            send_byte(gen_start);
            nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 2)
                                                 : $urandom_range(0, FRAME_BYTES);
            repeat (nbytes) begin
                send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(0, (gen_timeout < 3) ? gen_timeout : 3)) send_tick();
                end
            end
            if ($urandom_range(0, 5) != 0) send_byte(gen_end);
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 2)) send_tick();
        end else if (pick < 75) begin
            send_byte(gen_start);
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
            nticks = gen_timeout + 1;
            if (gen_timeout > 12 && $urandom_range(0, 3) != 0) nticks = $urandom_range(1, 4);
            repeat (nticks) send_tick();
        end else begin
            repeat ($urandom_range(1, 6)) begin
                pick = $urandom_range(0, 7);
                if (pick < 4) send_tick();
                else if (pick == 4) send_byte(gen_start);
                else if (pick == 5) send_byte(gen_end);
                else send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic run_phase(input int count);
        int target;
        target = words_sent + count;
        while (words_sent < target) random_burst();
    endtask

    // stimulus
    initial begin
        i_rst_n <= 1'b0;
        word_ch.valid <= 1'b0;
        word_ch.opcode <= OP_BYTE;
        word_ch.rx_byte <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_START_BYTE;
        cfg_ch.data <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on reset register values
        foreach (directed_rows[i]) send_word(directed_rows[i]);
        drain();

        // register extremes
        write_cfg(8'h00, 8'hFF, 8'h00, 1'b0);
        run_phase(PHASE_WORDS);
        drain();

        write_cfg(8'hFF, 8'h00, 8'd254, 1'b1);
        run_phase(PHASE_WORDS);
        drain();

        // saturating gap counter never times out
        write_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), GAP_MAX, 1'b0);
        send_byte(gen_start);
        send_byte(8'($urandom_range(0, 255)));
        repeat (260) send_tick();
        send_byte(gen_end);
        send_tick();
        run_phase(PHASE_WORDS / 2);
        drain();

        write_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(1, 6)), 1'b1);
        run_phase(PHASE_WORDS);
        drain();

        // same value opens and closes
        write_cfg(8'h7E, 8'h7E, 8'd3, 1'b0);
        run_phase(PHASE_WORDS / 2);
        drain();

        write_cfg(START_BYTE_RST, END_BYTE_RST, TIMEOUT_RST, 1'b0);
        run_phase(PHASE_WORDS);
        drain();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
sv/dfr_pkg.sv
sv/dfr_if.sv
sv/dfr_cfg_regs.sv
sv/dfr_frame_core.sv
sv/delimited_frame_receiver_top.sv
test/testbench.sv
